FILE: hw/rtl/sach_pkg.sv
// Shared types, constants and codes for the sequenced actuator command handler.
package sach_pkg;

    localparam int SOLENOID_COUNT = 4;
    localparam int IGNITER_COUNT  = 1;
    localparam int LIGHT_COUNT    = 4;
    localparam int BYTE_SLOTS     = 4;

    localparam int SEQ_W     = 32;
    localparam int CODE_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = $clog2(BYTE_SLOTS);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] SOLENOID_BASE_RST = 16'd100;
    localparam logic [CODE_W-1:0] IGNITER_BASE_RST  = 16'd200;
    localparam logic [CODE_W-1:0] LIGHT_BASE_RST    = 16'd300;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOLENOID_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNITER_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BASE    = 2'd2;

    localparam logic FUNC_COMMAND = 1'b0;
    localparam logic FUNC_REPORT  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_SOLENOID = 2'd1,
        KIND_IGNITER  = 2'd2,
        KIND_LIGHT    = 2'd3
    } kind_t;

    typedef logic [BYTE_SLOTS-1:0][BYTE_W-1:0] act_bytes_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [CODE_W-1:0]    data;
    } cfg_wr_t;

    // one queued job: ack plus telemetry snapshots; tel_mask bit 0 solenoid,
    // bit 1 igniter, bit 2 light
    typedef struct packed {
        logic [SEQ_W-1:0] ack_seq;
        logic [2:0]       tel_mask;
        act_bytes_t       sol;
        act_bytes_t       ign;
        act_bytes_t       light;
    } job_t;

endpackage

FILE: hw/rtl/sach_cmd_if.sv
// Command channel interface: valid/ready plus command payload.
interface sach_cmd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] cmd_seq;
    logic [15:0] control_code;
    logic [31:0] new_value;

    modport source (output valid, output func, output cmd_seq, output control_code,
                    output new_value, input ready);
    modport sink (input valid, input func, input cmd_seq, input control_code,
                  input new_value, output ready);
endinterface

FILE: hw/rtl/sach_rsp_if.sv
// Result channel interface: valid/ready plus result payload.
interface sach_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] ack_seq;
    logic [7:0]  byte_zero;
    logic [7:0]  byte_one;
    logic [7:0]  byte_two;
    logic [7:0]  byte_three;
    logic        last;

    modport source (output valid, output kind, output ack_seq, output byte_zero,
                    output byte_one, output byte_two, output byte_three,
                    output last, input ready);
    modport sink (input valid, input kind, input ack_seq, input byte_zero,
                  input byte_one, input byte_two, input byte_three,
                  input last, output ready);
endinterface

FILE: hw/rtl/sequenced_actuator_command_handler.sv
// Top level of the sequenced actuator command handler.
//
// The block takes one command beat on cmd and answers on rsp with an ack beat
// carrying the last accepted sequence number, followed by a telemetry beat for
// each actuator group the command wrote (solenoid, igniter, light, in that
// order); a report beat (func 1) answers with the ack and all three groups.
// The final beat of each answer has last set. A command beat is taken
// whenever the two-entry job queue has room; the front end checks the
// sequence number, updates the actuator bytes and snapshots them into the job.
// The back end then loads one result beat per cycle into its output register
// while rsp is not stalled: one beat for an ack-only answer, two for a command
// that writes one group, up to four for a report or for overlapping code ranges.
// That output register sets the sustained rate: two beats per item for
// ordinary actuator commands, with the queue letting the command side run
// ahead while rsp is stalled. Configuration writes (cfg_we, cfg_index,
// cfg_wdata) are registered; index 0 is solenoid_base, 1 igniter_base,
// 2 light_base, and other indexes are ignored. Write them only while idle.
module sequenced_actuator_command_handler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sach_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sach_pkg::CODE_W-1:0]          cfg_wdata,
    sach_cmd_if.sink                             cmd,
    sach_rsp_if.source                           rsp
);
    import sach_pkg::*;

    cfg_wr_t cfg;
    job_t    push_job;
    job_t    head_job;
    logic    push;
    logic    pop;
    logic    full;
    logic    head_valid;

    // gather the config write port into one bundle for the front end
    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_wdata;
    end

    sach_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    sach_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (push_job),
        .pop        (pop),
        .dout       (head_job),
        .full       (full),
        .head_valid (head_valid)
    );

    sach_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_job),
        .pop        (pop),
        .rsp        (rsp)
    );

endmodule

FILE: hw/rtl/sach_front.sv
// Front end: config registers, sequence check, actuator state update, job build.
module sach_front (
    input  logic              clk,
    input  logic              rst_n,
    input  sach_pkg::cfg_wr_t cfg,
    sach_cmd_if.sink          cmd,
    input  logic              full,
    output logic              push,
    output sach_pkg::job_t    job
);
    import sach_pkg::*;

    logic [CODE_W-1:0] sol_base_reg, sol_base_next;
    logic [CODE_W-1:0] ign_base_reg, ign_base_next;
    logic [CODE_W-1:0] light_base_reg, light_base_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    act_bytes_t        sol_reg, sol_next;
    act_bytes_t        ign_reg, ign_next;
    act_bytes_t        light_reg, light_next;

    logic              seq_ok;
    logic              upd;
    logic              fits;
    logic              sol_hit, ign_hit, light_hit;
    logic [SLOT_W-1:0] sol_idx, ign_idx, light_idx;
    logic [BYTE_W-1:0] wr_byte;

    // range check without 16-bit wrap of base + count
    function automatic logic in_range(input logic [CODE_W-1:0] code,
                                      input logic [CODE_W-1:0] base,
                                      input logic [2:0]        count);
        logic [CODE_W:0] lim;
        lim = {1'b0, base} + {{(CODE_W-2){1'b0}}, count};
        return (code >= base) && ({1'b0, code} < lim);
    endfunction

    always_comb
    begin
        cmd.ready = !full;
        push      = cmd.valid && !full;
        seq_ok    = (cmd.cmd_seq == seq_reg + 32'd1);
        upd       = push && (cmd.func == FUNC_COMMAND) && seq_ok;
        fits      = (cmd.new_value[VALUE_W-1:BYTE_W] == '0);
        wr_byte   = cmd.new_value[BYTE_W-1:0];

        sol_hit   = in_range(cmd.control_code, sol_base_reg, 3'(SOLENOID_COUNT));
        ign_hit   = in_range(cmd.control_code, ign_base_reg, 3'(IGNITER_COUNT));
        light_hit = in_range(cmd.control_code, light_base_reg, 3'(LIGHT_COUNT));
        sol_idx   = SLOT_W'(cmd.control_code - sol_base_reg);
        ign_idx   = SLOT_W'(cmd.control_code - ign_base_reg);
        light_idx = SLOT_W'(cmd.control_code - light_base_reg);

        seq_next   = upd ? cmd.cmd_seq : seq_reg;
        sol_next   = sol_reg;
        ign_next   = ign_reg;
        light_next = light_reg;
        if (upd && fits && sol_hit)
        begin
            sol_next[sol_idx] = wr_byte;
        end
        if (upd && fits && ign_hit)
        begin
            ign_next[ign_idx] = wr_byte;
        end
        if (upd && fits && light_hit)
        begin
            light_next[light_idx] = wr_byte;
        end

        sol_base_next   = sol_base_reg;
        ign_base_next   = ign_base_reg;
        light_base_next = light_base_reg;
        if (cfg.we)
        begin
            case (cfg.index)
                CFG_SOLENOID_BASE: sol_base_next   = cfg.data;
                CFG_IGNITER_BASE:  ign_base_next   = cfg.data;
                CFG_LIGHT_BASE:    light_base_next = cfg.data;
                default:           ;
            endcase
        end

        job.ack_seq = seq_next;
        if (cmd.func == FUNC_REPORT)
        begin
            job.tel_mask = 3'b111;
        end
        else if (upd && fits)
        begin
            job.tel_mask = {light_hit, ign_hit, sol_hit};
        end
        else
        begin
            job.tel_mask = 3'b000;
        end
        job.sol   = sol_next;
        job.ign   = ign_next;
        job.light = light_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sol_base_reg   <= SOLENOID_BASE_RST;
            ign_base_reg   <= IGNITER_BASE_RST;
            light_base_reg <= LIGHT_BASE_RST;
            seq_reg        <= '0;
            sol_reg        <= '0;
            ign_reg        <= '0;
            light_reg      <= '0;
        end
        else
        begin
            sol_base_reg   <= sol_base_next;
            ign_base_reg   <= ign_base_next;
            light_base_reg <= light_base_next;
            seq_reg        <= seq_next;
            sol_reg        <= sol_next;
            ign_reg        <= ign_next;
            light_reg      <= light_next;
        end
    end

`ifndef SYNTHESIS
    a_seq_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != $past(seq_reg)) |-> (seq_reg == $past(seq_reg) + 32'd1))
        else $error("accepted sequence moved by other than one");
`endif

endmodule

FILE: hw/rtl/sach_queue.sv
// Short job queue between the front and back ends.
module sach_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sach_pkg::job_t din,
    input  logic           pop,
    output sach_pkg::job_t dout,
    output logic           full,
    output logic           head_valid
);
    import sach_pkg::*;

    job_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        full        = (count_reg == COUNT_W'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        dout        = mem[rd_ptr_reg];
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_empty_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty but pointers differ");
`endif

endmodule

FILE: hw/rtl/sach_back.sv
// Back end: walks each job's ack and telemetry results into the output register.
module sach_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  sach_pkg::job_t head,
    output logic           pop,
    sach_rsp_if.source     rsp
);
    import sach_pkg::*;

    logic [3:0]       done_reg, done_next;
    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0] out_seq_reg, out_seq_next;
    act_bytes_t       out_bytes_reg, out_bytes_next;
    logic             out_last_reg, out_last_next;

    logic [3:0] want;
    logic [3:0] sel_oh;
    logic       sel_last;
    kind_t      sel_kind;
    logic       load;

    always_comb
    begin
        // bit 0 ack, then solenoid, igniter, light
        want = {head.tel_mask, 1'b1} & ~done_reg;
        if (want[0])
        begin
            sel_kind = KIND_ACK;
        end
        else if (want[1])
        begin
            sel_kind = KIND_SOLENOID;
        end
        else if (want[2])
        begin
            sel_kind = KIND_IGNITER;
        end
        else
        begin
            sel_kind = KIND_LIGHT;
        end
        sel_oh   = 4'(4'b0001 << sel_kind);
        sel_last = ((want & ~sel_oh) == 4'b0000);
        load     = head_valid && (!out_valid_reg || rsp.ready);
        pop      = load && sel_last;

        done_next = done_reg;
        if (load)
        begin
            done_next = sel_last ? 4'b0000 : (done_reg | sel_oh);
        end

        out_valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_bytes_next = out_bytes_reg;
        out_last_next  = out_last_reg;
        if (load)
        begin
            out_kind_next = sel_kind;
            out_last_next = sel_last;
            out_seq_next  = (sel_kind == KIND_ACK) ? head.ack_seq : '0;
            case (sel_kind)
                KIND_SOLENOID: out_bytes_next = head.sol;
                KIND_IGNITER:  out_bytes_next = head.ign;
                KIND_LIGHT:    out_bytes_next = head.light;
                default:       out_bytes_next = '0;
            endcase
        end

        rsp.valid      = out_valid_reg;
        rsp.kind       = out_kind_reg;
        rsp.ack_seq    = out_seq_reg;
        rsp.byte_zero  = out_bytes_reg[0];
        rsp.byte_one   = out_bytes_reg[1];
        rsp.byte_two   = out_bytes_reg[2];
        rsp.byte_three = out_bytes_reg[3];
        rsp.last       = out_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_seq_reg   <= out_seq_next;
        out_bytes_reg <= out_bytes_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    a_new_job_starts_with_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (done_reg == 4'b0000)) |-> (sel_kind == KIND_ACK))
        else $error("job did not start with an ack");

    a_done_within_job: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg & ~({head.tel_mask, 1'b1} & {4{head_valid}})) == 4'b0000)
        else $error("progress mask outside the current job");

    a_pop_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && out_last_reg))
        else $error("job retired without a last beat");
`endif

endmodule
